@@ hw/rtl/obsp_pkg.sv @@
// Shared types, constants and helpers of the oriented box support point block
`default_nettype none
package obsp_pkg;
    localparam int MIN_EXTENT_DEF = 1;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QFRAC          = 30;
    localparam int NUM_CORNERS    = 8;
    localparam int ROOT_W         = 32;

    localparam logic [2:0] CORNER_SEL [NUM_CORNERS] =
        '{3'd0, 3'd1, 3'd2, 3'd4, 3'd7, 3'd6, 3'd5, 3'd3};

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    typedef enum logic [2:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] dir_x;
        logic [31:0] dir_y;
        logic [31:0] dir_z;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] quat_w;
        logic [31:0] quat_x;
        logic [31:0] quat_y;
        logic [31:0] quat_z;
        logic [31:0] bias;
    } t_in;

    typedef struct packed {
        logic [31:0] support_x;
        logic [31:0] support_y;
        logic [31:0] support_z;
        logic        box_valid;
    } t_out;

    typedef struct packed {
        logic [2:0][31:0] lo;
        logic [2:0][31:0] hi;
    } t_box;

    typedef struct packed {
        logic [2:0][31:0] dir;
        logic [2:0][31:0] pos;
        logic [31:0]      bias;
        logic             bv;
    } t_side;

    typedef struct packed {
        logic [2:0][31:0] best;
        logic [2:0][31:0] dir;
        logic [31:0]      bias;
        logic             bv;
    } t_cout;

    typedef struct packed {
        logic [2:0][31:0] best;
        logic [2:0][62:0] num;
        logic [2:0]       neg;
        logic             bv;
    } t_nside;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        if (v > S32_MAX) begin
            return 32'h7fffffff;
        end else if (v < S32_MIN) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/obsp_corner.sv @@
// Rotation matrix, world corners, dot products and best-corner tree
`default_nettype none
module obsp_corner #(
    parameter int FRAC_BITS  = obsp_pkg::FRAC_BITS_DEF,
    parameter int MIN_EXTENT = obsp_pkg::MIN_EXTENT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  obsp_pkg::t_in   i_data,
    input  obsp_pkg::t_box  i_box,
    output logic            o_valid,
    output obsp_pkg::t_cout o_data
);
    import obsp_pkg::*;

    localparam int NS = 9;
    localparam logic signed [37:0] ONE = 38'sd1 <<< QFRAC;

    logic [NS-1:0] r_vld;
    t_side         r_side [NS];
    t_side         n_side;

    logic signed [33:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic [31:0]        n_m [3][3];
    logic [31:0]        r_m [3][3];
    logic signed [33:0] n_tlo [3][3];
    logic signed [33:0] n_thi [3][3];
    logic signed [33:0] r_tlo [3][3];
    logic signed [33:0] r_thi [3][3];
    logic [2:0][31:0]   n_w [NUM_CORNERS];
    logic [2:0][31:0]   r_w [NUM_CORNERS];
    logic [2:0][31:0]   r_w5 [NUM_CORNERS];
    logic [2:0][31:0]   r_w6 [NUM_CORNERS];
    logic signed [63:0] n_dp [NUM_CORNERS][3];
    logic signed [63:0] r_dp [NUM_CORNERS][3];
    logic signed [65:0] r_dot [NUM_CORNERS];
    logic signed [65:0] r_d7 [4];
    logic [2:0][31:0]   r_w7 [4];
    logic signed [65:0] r_d8 [2];
    logic [2:0][31:0]   r_w8 [2];
    logic [2:0][31:0]   r_w9;

    function automatic logic signed [33:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return 34'(p >>> QFRAC);
    endfunction

    always_comb begin
        logic signed [32:0] ext;
        n_side.dir  = {i_data.dir_z, i_data.dir_y, i_data.dir_x};
        n_side.pos  = {i_data.pos_z, i_data.pos_y, i_data.pos_x};
        n_side.bias = i_data.bias;
        n_side.bv   = 1'b1;
        for (int j = 0; j < 3; j++) begin
            ext = 33'($signed(i_box.hi[j])) - 33'($signed(i_box.lo[j]));
            if (ext <= 33'(MIN_EXTENT)) begin
                n_side.bv = 1'b0;
            end
        end
    end

    always_comb begin
        logic signed [37:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
        e_xx = 38'(r_xx);
        e_yy = 38'(r_yy);
        e_zz = 38'(r_zz);
        e_xy = 38'(r_xy);
        e_xz = 38'(r_xz);
        e_yz = 38'(r_yz);
        e_wx = 38'(r_wx);
        e_wy = 38'(r_wy);
        e_wz = 38'(r_wz);
        n_m[0][0] = sat32(66'(ONE - ((e_yy + e_zz) <<< 1)));
        n_m[0][1] = sat32(66'((e_xy - e_wz) <<< 1));
        n_m[0][2] = sat32(66'((e_xz + e_wy) <<< 1));
        n_m[1][0] = sat32(66'((e_xy + e_wz) <<< 1));
        n_m[1][1] = sat32(66'(ONE - ((e_xx + e_zz) <<< 1)));
        n_m[1][2] = sat32(66'((e_yz - e_wx) <<< 1));
        n_m[2][0] = sat32(66'((e_xz - e_wy) <<< 1));
        n_m[2][1] = sat32(66'((e_yz + e_wx) <<< 1));
        n_m[2][2] = sat32(66'(ONE - ((e_xx + e_yy) <<< 1)));
    end

    always_comb begin
        logic signed [63:0] pl, ph;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                pl = $signed(r_m[i][j]) * $signed(i_box.lo[j]);
                ph = $signed(r_m[i][j]) * $signed(i_box.hi[j]);
                n_tlo[i][j] = 34'(pl >>> QFRAC);
                n_thi[i][j] = 34'(ph >>> QFRAC);
            end
        end
    end

    always_comb begin
        logic signed [35:0] s;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            for (int i = 0; i < 3; i++) begin
                s = 36'($signed(r_side[2].pos[i]));
                for (int j = 0; j < 3; j++) begin
                    s = s + 36'(CORNER_SEL[k][j] ? r_thi[i][j] : r_tlo[i][j]);
                end
                n_w[k][i] = sat32(66'(s));
            end
        end
    end

    always_comb begin
        logic signed [63:0] p;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            for (int i = 0; i < 3; i++) begin
                p = $signed(r_side[3].dir[i]) * $signed(r_w[k][i]);
                n_dp[k][i] = p >>> FRAC_BITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= n_side;
            for (int s = 1; s < NS; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_xx <= qmul(i_data.quat_x, i_data.quat_x);
            r_yy <= qmul(i_data.quat_y, i_data.quat_y);
            r_zz <= qmul(i_data.quat_z, i_data.quat_z);
            r_xy <= qmul(i_data.quat_x, i_data.quat_y);
            r_xz <= qmul(i_data.quat_x, i_data.quat_z);
            r_yz <= qmul(i_data.quat_y, i_data.quat_z);
            r_wx <= qmul(i_data.quat_w, i_data.quat_x);
            r_wy <= qmul(i_data.quat_w, i_data.quat_y);
            r_wz <= qmul(i_data.quat_w, i_data.quat_z);
            r_m   <= n_m;
            r_tlo <= n_tlo;
            r_thi <= n_thi;
            r_w   <= n_w;
            r_w5  <= r_w;
            r_w6  <= r_w5;
            r_dp  <= n_dp;
            for (int k = 0; k < NUM_CORNERS; k++) begin
                r_dot[k] <= 66'(r_dp[k][0]) + 66'(r_dp[k][1]) + 66'(r_dp[k][2]);
            end
            for (int p = 0; p < 4; p++) begin
                if (r_dot[2*p+1] > r_dot[2*p]) begin
                    r_d7[p] <= r_dot[2*p+1];
                    r_w7[p] <= r_w6[2*p+1];
                end else begin
                    r_d7[p] <= r_dot[2*p];
                    r_w7[p] <= r_w6[2*p];
                end
            end
            for (int p = 0; p < 2; p++) begin
                if (r_d7[2*p+1] > r_d7[2*p]) begin
                    r_d8[p] <= r_d7[2*p+1];
                    r_w8[p] <= r_w7[2*p+1];
                end else begin
                    r_d8[p] <= r_d7[2*p];
                    r_w8[p] <= r_w7[2*p];
                end
            end
            r_w9 <= (r_d8[1] > r_d8[0]) ? r_w8[1] : r_w8[0];
        end
    end

    assign o_valid     = r_vld[NS-1];
    assign o_data.best = r_w9;
    assign o_data.dir  = r_side[NS-1].dir;
    assign o_data.bias = r_side[NS-1].bias;
    assign o_data.bv   = r_side[NS-1].bv;
endmodule
`default_nettype wire

@@ hw/rtl/obsp_scale.sv @@
// Direction scaling, squared length, bias products and pipelined square root
`default_nettype none
module obsp_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  obsp_pkg::t_cout  i_data,
    output logic             o_valid,
    output logic [31:0]      o_len,
    output obsp_pkg::t_nside o_side
);
    import obsp_pkg::*;

    localparam int NF = 5;

    logic [NF-1:0]     r_fv;
    t_cout             r_fc [NF];
    logic [31:0]       r1_or;
    logic [3:0]        r2_nz;
    logic [3:0][2:0]   r2_lz;
    logic [4:0]        r3_sh;
    logic [2:0][32:0]  r4_sd;
    logic [2:0][31:0]  r4_abs;
    logic [2:0][63:0]  r5_sq;
    logic [2:0][63:0]  r5_num;
    logic [ROOT_W:0]   r_qv;
    logic [63:0]       r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    t_nside            r_qs   [ROOT_W+1];
    logic [31:0]       n_or;
    logic [4:0]        n_sh;
    t_nside            n_qs;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [2:0] lz8(input logic [7:0] v);
        logic [2:0] lz;
        lz = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                lz = 3'(7 - i);
            end
        end
        return lz;
    endfunction

    assign n_or = abs32(i_data.dir[0]) | abs32(i_data.dir[1]) | abs32(i_data.dir[2]);

    always_comb begin
        logic [5:0] lzc;
        lzc = 6'd32;
        for (int b = 0; b < 4; b++) begin
            if (r2_nz[b]) begin
                lzc = 6'((3 - b) * 8) + 6'(r2_lz[b]);
            end
        end
        n_sh = (lzc == 6'd32 || lzc == 6'd0) ? 5'd0 : 5'(lzc - 6'd1);
    end

    always_comb begin
        logic [63:0] m;
        n_qs.best = r_fc[4].best;
        n_qs.bv   = r_fc[4].bv;
        for (int i = 0; i < 3; i++) begin
            n_qs.neg[i] = r5_num[i][63];
            m           = r5_num[i][63] ? (~r5_num[i] + 64'd1) : r5_num[i];
            n_qs.num[i] = m[62:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_qv <= '0;
        end else if (i_en) begin
            r_fv <= {r_fv[NF-2:0], i_valid};
            r_qv <= {r_qv[ROOT_W-1:0], r_fv[NF-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [32:0] sd;
        logic signed [63:0] p;
        if (i_en) begin
            r_fc[0] <= i_data;
            for (int s = 1; s < NF; s++) begin
                r_fc[s] <= r_fc[s-1];
            end
            r1_or <= n_or;
            for (int b = 0; b < 4; b++) begin
                r2_nz[b] <= |r1_or[b*8 +: 8];
                r2_lz[b] <= lz8(r1_or[b*8 +: 8]);
            end
            r3_sh <= n_sh;
            for (int i = 0; i < 3; i++) begin
                sd        = 33'($signed(r_fc[2].dir[i])) <<< r3_sh;
                r4_sd[i]  <= sd;
                r4_abs[i] <= sd[32] ? 32'(-sd) : 32'(sd);
                p         = $signed(r_fc[3].bias) * $signed(r4_sd[i]);
                r5_sq[i]  <= 64'(r4_abs[i]) * 64'(r4_abs[i]);
                r5_num[i] <= p;
            end
            r_rem[0]  <= r5_sq[0] + r5_sq[1] + r5_sq[2];
            r_root[0] <= '0;
            r_qs[0]   <= n_qs;
        end
    end

    for (genvar s = 0; s < ROOT_W; s++) begin : g_root
        localparam int B = ROOT_W - 1 - s;
        logic [65:0] w_trial;
        logic        w_take;
        assign w_trial = (66'(r_root[s]) << (B + 1)) + (66'(1) << (2 * B));
        assign w_take  = 66'(r_rem[s]) >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= w_take ? 64'(66'(r_rem[s]) - w_trial) : r_rem[s];
                r_root[s+1] <= w_take ? (r_root[s] | (ROOT_W'(1) << B)) : r_root[s];
                r_qs[s+1]   <= r_qs[s];
            end
        end
    end

    assign o_valid = r_qv[ROOT_W];
    assign o_len   = r_root[ROOT_W];
    assign o_side  = r_qs[ROOT_W];
endmodule
`default_nettype wire

@@ hw/rtl/obsp_divide.sv @@
// Three-lane restoring divider for the bias offset along the unit direction
`default_nettype none
module obsp_divide (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [31:0]      i_len,
    input  obsp_pkg::t_nside i_side,
    output logic             o_valid,
    output obsp_pkg::t_nside o_side,
    output logic [2:0][33:0] o_off
);
    import obsp_pkg::*;

    localparam int QW = 32;

    logic [QW:0]      r_dv;
    logic [2:0][62:0] r_rm  [QW+1];
    logic [2:0][31:0] r_q   [QW+1];
    logic [31:0]      r_len [QW+1];
    t_nside           r_ds  [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (i_en) begin
            r_dv <= {r_dv[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rm[0]  <= i_side.num;
            r_q[0]   <= '0;
            r_len[0] <= i_len;
            r_ds[0]  <= i_side;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int B = QW - 1 - s;
        logic [63:0] w_dvs;
        assign w_dvs = 64'(r_len[s]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    if (64'(r_rm[s][l]) >= w_dvs) begin
                        r_rm[s+1][l] <= 63'(64'(r_rm[s][l]) - w_dvs);
                        r_q[s+1][l]  <= r_q[s][l] | (32'd1 << B);
                    end else begin
                        r_rm[s+1][l] <= r_rm[s][l];
                        r_q[s+1][l]  <= r_q[s][l];
                    end
                end
                r_len[s+1] <= r_len[s];
                r_ds[s+1]  <= r_ds[s];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_len[QW] == '0) begin
                o_off[l] = '0;
            end else if (r_ds[QW].neg[l]) begin
                o_off[l] = 34'd0 - 34'(r_q[QW][l]);
            end else begin
                o_off[l] = 34'(r_q[QW][l]);
            end
        end
    end

    assign o_valid = r_dv[QW];
    assign o_side  = r_ds[QW];
endmodule
`default_nettype wire

@@ hw/rtl/oriented_box_support_point.sv @@
// Top level: box registers, corner search, offset along direction, output stage
// Path from input accept to result: corner search, length and square root, divide, output register.
// Throughput: one item per cycle; the whole pipeline advances unless the output is held.
// The square root and the divider retire one bit per stage, which sets the depth.
// Reset: synchronous active low; clears valid bits and box registers (all zero).
// Configuration writes are taken every cycle.
`default_nettype none
module oriented_box_support_point #(
    parameter int MIN_EXTENT = obsp_pkg::MIN_EXTENT_DEF,
    parameter int FRAC_BITS  = obsp_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  obsp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output obsp_pkg::t_out o_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import obsp_pkg::*;

    logic             w_en;
    t_box             r_box;
    logic             w_cor_vld;
    t_cout            w_cor;
    logic             w_scl_vld;
    logic [31:0]      w_len;
    t_nside           w_scl;
    logic             w_div_vld;
    t_nside           w_div;
    logic [2:0][33:0] w_off;
    logic             r_out_vld;
    t_out             r_out;
    t_out             n_out;

    assign w_en        = !r_out_vld || i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_X: r_box.lo[0] <= i_cfg_data;
                CFG_MIN_Y: r_box.lo[1] <= i_cfg_data;
                CFG_MIN_Z: r_box.lo[2] <= i_cfg_data;
                CFG_MAX_X: r_box.hi[0] <= i_cfg_data;
                CFG_MAX_Y: r_box.hi[1] <= i_cfg_data;
                CFG_MAX_Z: r_box.hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    obsp_corner #(
        .FRAC_BITS  (FRAC_BITS),
        .MIN_EXTENT (MIN_EXTENT)
    ) u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_box   (r_box),
        .o_valid (w_cor_vld),
        .o_data  (w_cor)
    );

    obsp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cor_vld),
        .i_data  (w_cor),
        .o_valid (w_scl_vld),
        .o_len   (w_len),
        .o_side  (w_scl)
    );

    obsp_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_scl_vld),
        .i_len   (w_len),
        .i_side  (w_scl),
        .o_valid (w_div_vld),
        .o_side  (w_div),
        .o_off   (w_off)
    );

    always_comb begin
        n_out.box_valid = w_div.bv;
        n_out.support_x = sat32(66'($signed(w_div.best[0])) + 66'($signed(w_off[0])));
        n_out.support_y = sat32(66'($signed(w_div.best[1])) + 66'($signed(w_off[1])));
        n_out.support_z = sat32(66'($signed(w_div.best[2])) + 66'($signed(w_off[2])));
        if (!w_div.bv) begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.box_valid |->
            o_data.support_x == '0 && o_data.support_y == '0 && o_data.support_z == '0)
        else $error("invalid box item carries a nonzero point");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_div_vld) && $stable(w_cor_vld) && $stable(w_scl_vld))
        else $error("pipeline moved while output held");

    a_stall_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en && w_div_vld |=> $stable(w_div) && $stable(w_off))
        else $error("divider result changed while output held");
endmodule
`default_nettype wire

@@ tb/obsp_checker.sv @@
// Checker: predicts each support point from observed items and compares results
module obsp_checker
    import obsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_dut,
    input  t_in         i_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint EXT_MIN  = 1;
    localparam int     FRAC     = 16;
    localparam int     QBITS    = 30;
    localparam longint LIM_HI   = 64'sd2147483647;
    localparam longint LIM_LO   = -64'sd2147483648;
    localparam logic [2:0] ORDER [8] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd7, 3'd6, 3'd5, 3'd3};

    longint box_lo [3];
    longint box_hi [3];
    t_out   support_q [$];

    function automatic longint clamp32(longint v);
        if (v > LIM_HI) begin
            return LIM_HI;
        end
        if (v < LIM_LO) begin
            return LIM_LO;
        end
        return v;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_out predict_support(t_in x);
        t_out   res;
        longint d [3];
        longint p [3];
        longint m [3][3];
        longint c [3];
        longint w [3];
        longint best [3];
        longint sd [3];
        longint off [3];
        longint qw, qx, qy, qz, bias, one, dot, best_dot, s, mag, a;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint unsigned sum, len;
        int sh;
        res = '0;
        d[0] = $signed(x.dir_x); d[1] = $signed(x.dir_y); d[2] = $signed(x.dir_z);
        p[0] = $signed(x.pos_x); p[1] = $signed(x.pos_y); p[2] = $signed(x.pos_z);
        qw = $signed(x.quat_w); qx = $signed(x.quat_x);
        qy = $signed(x.quat_y); qz = $signed(x.quat_z);
        bias = $signed(x.bias);
        one = 64'sd1 <<< QBITS;
        for (int i = 0; i < 3; i++) begin
            if (box_hi[i] - box_lo[i] <= EXT_MIN) begin
                return res;
            end
        end
        xx = (qx * qx) >>> QBITS; yy = (qy * qy) >>> QBITS; zz = (qz * qz) >>> QBITS;
        xy = (qx * qy) >>> QBITS; xz = (qx * qz) >>> QBITS; yz = (qy * qz) >>> QBITS;
        wx = (qw * qx) >>> QBITS; wy = (qw * qy) >>> QBITS; wz = (qw * qz) >>> QBITS;
        m[0][0] = one - 2 * (yy + zz); m[0][1] = 2 * (xy - wz); m[0][2] = 2 * (xz + wy);
        m[1][0] = 2 * (xy + wz); m[1][1] = one - 2 * (xx + zz); m[1][2] = 2 * (yz - wx);
        m[2][0] = 2 * (xz - wy); m[2][1] = 2 * (yz + wx); m[2][2] = one - 2 * (xx + yy);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = clamp32(m[i][j]);
        best_dot = 0;
        for (int k = 0; k < 8; k++) begin
            dot = 0;
            for (int j = 0; j < 3; j++)
                c[j] = ORDER[k][j] ? box_hi[j] : box_lo[j];
            for (int i = 0; i < 3; i++) begin
                s = p[i];
                for (int j = 0; j < 3; j++)
                    s += (m[i][j] * c[j]) >>> QBITS;
                w[i] = clamp32(s);
                dot += (d[i] * w[i]) >>> FRAC;
            end
            if (k == 0 || dot > best_dot) begin
                best_dot = dot;
                best = w;
            end
        end
        mag = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            a = d[i] < 0 ? -d[i] : d[i];
            if (a > mag) mag = a;
        end
        if (mag != 0)
            while (mag < (64'sd1 <<< 30)) begin
                mag = mag <<< 1;
                sh++;
            end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            sd[i] = d[i] <<< sh;
            a = sd[i] < 0 ? -sd[i] : sd[i];
            sum += longint'(unsigned'(a)) * longint'(unsigned'(a));
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++)
            off[i] = (len == 0) ? 0 : (bias * sd[i]) / longint'(len);
        res.support_x = 32'(clamp32(best[0] + off[0]));
        res.support_y = 32'(clamp32(best[1] + off[1]));
        res.support_z = 32'(clamp32(best[2] + off[2]));
        res.box_valid = 1'b1;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = 0;
            box_hi[i] = 0;
        end
    end

    assign o_pending = support_q.size();

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_X: box_lo[0] = longint'($signed(i_cfg_data));
                    CFG_MIN_Y: box_lo[1] = longint'($signed(i_cfg_data));
                    CFG_MIN_Z: box_lo[2] = longint'($signed(i_cfg_data));
                    CFG_MAX_X: box_hi[0] = longint'($signed(i_cfg_data));
                    CFG_MAX_Y: box_hi[1] = longint'($signed(i_cfg_data));
                    CFG_MAX_Z: box_hi[2] = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_valid && i_ready_dut) begin
                support_q = {support_q, predict_support(i_data)};
            end
            if (i_out_valid && i_out_ready) begin
                if (support_q.size() == 0) begin
                    $display("%0t: unexpected item, actual %h", $realtime, i_out_data);
                    o_errors++;
                end else begin
                    exp_r = support_q.pop_front();
                    check_field("support_x", exp_r.support_x, i_out_data.support_x);
                    check_field("support_y", exp_r.support_y, i_out_data.support_y);
                    check_field("support_z", exp_r.support_z, i_out_data.support_z);
                    check_field("box_valid", 32'(exp_r.box_valid), 32'(i_out_data.box_valid));
                end
            end
        end
    end
endmodule

@@ tb/testbench.sv @@
// Testbench top: drives box settings and queries, applies back pressure, reports verdict
module testbench;
    import obsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DRAIN_CYCLES = 100;
    localparam longint CYCLE_LIMIT  = 600000;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] MAX32   = 32'h7fff_ffff;
    localparam logic [31:0] MIN32   = 32'h8000_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          error_count;
    int          pending;
    bit          quiet;
    int          stall_left;
    longint      cycles;

    oriented_box_support_point DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    obsp_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_dut(o_ready), .i_data(i_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(error_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial stall_left = 0;

    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            stall_left <= 0;
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                           logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_MIN_X, lx);
        write_reg(CFG_MIN_Y, ly);
        write_reg(CFG_MIN_Z, lz);
        write_reg(CFG_MAX_X, hx);
        write_reg(CFG_MAX_Y, hy);
        write_reg(CFG_MAX_Z, hz);
    endtask

    task automatic send_query(t_in x);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data = x;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic t_in make_query(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                       logic [31:0] qw, logic [31:0] qx, logic [31:0] qy,
                                       logic [31:0] qz, logic [31:0] b);
        t_in x;
        x.dir_x = dx; x.dir_y = dy; x.dir_z = dz;
        x.pos_x = ONE_Q16; x.pos_y = -ONE_Q16; x.pos_z = 32'h0002_8000;
        x.quat_w = qw; x.quat_x = qx; x.quat_y = qy; x.quat_z = qz;
        x.bias = b;
        return x;
    endfunction

    function automatic logic [31:0] rand_small(int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_in rand_query();
        t_in x;
        int mode;
        mode = $urandom_range(0, 9);
        x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
        if (mode < 7) begin
            x.dir_x = rand_small(1 << 20); x.dir_y = rand_small(1 << 20);
            x.dir_z = rand_small(1 << 20);
            x.pos_x = rand_small(1 << 22); x.pos_y = rand_small(1 << 22);
            x.pos_z = rand_small(1 << 22);
            x.quat_w = rand_small(1 << 30); x.quat_x = rand_small(1 << 30);
            x.quat_y = rand_small(1 << 30); x.quat_z = rand_small(1 << 30);
            x.bias = rand_small(1 << 19);
            if (mode == 0) begin
                x.dir_x = '0; x.dir_y = '0; x.dir_z = '0;
            end else if (mode == 1) begin
                x.quat_w = ONE_Q30; x.quat_x = '0; x.quat_y = '0; x.quat_z = '0;
            end
        end
        return x;
    endfunction

    task automatic random_queries(int count);
        repeat (count) send_query(rand_query());
    endtask

    task automatic random_box();
        logic [31:0] lo [3];
        logic [31:0] hi [3];
        logic [31:0] t;
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                lo[i] = $urandom;
                hi[i] = $urandom;
            end else begin
                lo[i] = rand_small(1 << 21);
                hi[i] = rand_small(1 << 21);
            end
            if ($signed(lo[i]) > $signed(hi[i])) begin
                t = lo[i]; lo[i] = hi[i]; hi[i] = t;
            end
        end
        set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MIN_X;
        i_cfg_data = '0;
        quiet = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_query(make_query(ONE_Q16, '0, '0, ONE_Q30, '0, '0, '0, ONE_Q16));
        send_query(make_query(MIN32, MAX32, '0, MAX32, MIN32, MAX32, MIN32, MIN32));

        set_box(32'hfffe_0000, 32'hffff_0000, 32'hffff_8000,
                32'h0003_0000, ONE_Q16, 32'h0004_0000);
        write_reg(CFG_MAX_Z + 3'd1, 32'hdead_beef);
        write_reg(CFG_MAX_Z + 3'd2, 32'h1234_5678);
        send_query(make_query('0, '0, '0, ONE_Q30, '0, '0, '0, ONE_Q16));
        send_query(make_query(ONE_Q16, '0, '0, ONE_Q30, '0, '0, '0, '0));
        send_query(make_query('0, ONE_Q16, '0, ONE_Q30, '0, '0, '0, ONE_Q16));
        send_query(make_query('0, '0, -ONE_Q16, ONE_Q30, '0, '0, '0, -ONE_Q16));
        send_query(make_query(ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q30, '0, '0, '0, MAX32));
        send_query(make_query(MIN32, MIN32, MIN32, ONE_Q30, '0, '0, '0, MIN32));
        send_query(make_query(MAX32, MAX32, MAX32, '0, ONE_Q30, '0, '0, MAX32));
        send_query(make_query(1, '0, '0, '0, '0, ONE_Q30, '0, 1));
        send_query(make_query(-1, 1, -1, '0, '0, '0, ONE_Q30, -1));
        send_query(make_query(ONE_Q16, 32'h0000_8000, '0, MAX32, MAX32, MAX32, MAX32, '0));
        send_query(make_query(ONE_Q16, -ONE_Q16, ONE_Q16, MIN32, MIN32, MIN32, MIN32, '0));
        send_query(make_query(ONE_Q16, '0, '0, 32'h2d41_3ccd, '0, '0, 32'h2d41_3ccd,
                              ONE_Q16));
        send_query(make_query(ONE_Q16, ONE_Q16, '0, '0, '0, '0, '0, ONE_Q16));
        random_queries(120);

        set_box(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32);
        send_query(make_query(MAX32, MAX32, MAX32, ONE_Q30, '0, '0, '0, MAX32));
        send_query(make_query(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32, MAX32, MIN32));
        random_queries(80);

        set_box('0, '0, '0, 32'd1, ONE_Q16, ONE_Q16);
        random_queries(30);
        set_box(ONE_Q16, '0, '0, '0, ONE_Q16, ONE_Q16);
        random_queries(30);
        set_box('0, '0, 32'h0000_0005, 32'd2, 32'd2, 32'd7);
        random_queries(60);

        for (int ph = 0; ph < 6; ph++) begin
            random_box();
            random_queries(80);
        end

        set_box(32'hffff_0000, 32'hffff_0000, 32'hffff_0000, ONE_Q16, ONE_Q16, ONE_Q16);
        quiet = 1'b1;
        random_queries(150);
        @(negedge i_clk);
        i_valid = 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/obsp_pkg.sv
hw/rtl/obsp_corner.sv
hw/rtl/obsp_scale.sv
hw/rtl/obsp_divide.sv
hw/rtl/oriented_box_support_point.sv
tb/obsp_checker.sv
tb/testbench.sv
